// ===== hw/rtl/tt8_pkg.sv =====
package tt8_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ENCODING = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CYRILLIC_MODE = CSR_IDX_W'(1);

   localparam logic [7:0] ENC_SINGLE = 8'd0;
   localparam logic [7:0] ENC_BOM    = 8'd1;
   localparam logic [7:0] ENC_BE     = 8'd2;

   localparam logic [7:0] BOM_BIG_FIRST = 8'hFE;

   // one utf-8 sequence, bytes[0] goes out first
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      cnt;
   } utf8_seq_type;

   // one queued job: 1 to 3 result words for one input word
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      cnt;
      logic            data;
      logic            last;
   } tt8_job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } tt8_q_status_type;

   // windows-1251 upper half
   localparam logic [15:0] W1251_ROM [128] = '{
      16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
      16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
      16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
      16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
      16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
      16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
      16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
      16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
      16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
      16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
      16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
      16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
      16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
      16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
   };

   function automatic utf8_seq_type utf8_encode(input logic [15:0] cp);
      utf8_seq_type s;
      s = '0;
      if (cp <= 16'h007F) begin
         s.bytes[0] = cp[7:0];
         s.cnt = 2'd1;
      end else if (cp <= 16'h07FF) begin
         s.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
         s.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
         s.cnt = 2'd2;
      end else begin
         s.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
         s.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
         s.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
         s.cnt = 2'd3;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/tag_text_to_utf8_transcoder.sv =====
// tag text to utf-8 transcoder
// req channel: one raw string byte per word (req_in_byte) with req_last_in_string
// on the string's final byte. rsp channel: utf-8 words (rsp_out_byte) with
// rsp_byte_valid, rsp_run_last on the last word caused by an input byte and
// rsp_string_end on the last word of the string; a string whose last byte gives
// no data closes with one bare marker word (byte_valid low).
// csr channel: index 0 text_encoding, index 1 cyrillic_mode; always ready,
// write only between strings while the block is drained.
// throughput: the front accepts one byte per cycle while the job queue has
// room; the back sends one utf-8 word per cycle while the receiver is ready,
// so an input byte gives at most 3 output words (3 for a code unit at or above
// 0x800). rsp_valid comes from the output register, fed from the job queue.
// when the receiver stalls, the output word holds and the queue of
// QUEUE_DEPTH jobs fills, then req_ready drops.
// synchronous reset clears the csr registers, the string state, the output valid and the queue.
module tag_text_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = tt8_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_last_in_string,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_byte_valid,
   output logic                         rsp_run_last,
   output logic                         rsp_string_end,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tt8_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                   csr_data
);
   import tt8_pkg::*;

   tt8_q_status_type q_status;
   tt8_job_type      push_job;
   tt8_job_type      head;
   logic             push;
   logic             pop;

   tt8_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_last_in_string (req_last_in_string),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .q_status           (q_status),
      .push               (push),
      .job                (push_job)
   );

   tt8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   tt8_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

// ===== hw/rtl/tt8_front.sv =====
module tt8_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   input  logic                         req_last_in_string,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tt8_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                   csr_data,
   input  tt8_pkg::tt8_q_status_type    q_status,
   output logic                         push,
   output tt8_pkg::tt8_job_type         job
);
   import tt8_pkg::*;

   logic [7:0]   enc_ff;
   logic         cyr_ff;
   logic [1:0]   pos_ff, pos_in;
   logic [7:0]   held_ff, held_in;
   logic         phase_ff, phase_in;
   logic         be_ff, be_in;
   logic         stop_ff, stop_in;

   logic         accept;
   logic         do_pair;
   logic         pair_big;
   logic [15:0]  unit;
   logic [15:0]  sb_cp;
   utf8_seq_type unit_seq, sb_seq, seq;

   assign req_ready = !q_status.full;
   assign csr_ready = 1'b1;
   assign accept = req_valid && req_ready;

   assign pair_big = (enc_ff == ENC_BE) || be_ff;
   assign unit = pair_big ? {held_ff, req_in_byte} : {req_in_byte, held_ff};
   assign unit_seq = utf8_encode(unit);
   assign sb_cp = (cyr_ff && req_in_byte[7]) ? W1251_ROM[req_in_byte[6:0]]
                                             : {8'h00, req_in_byte};
   assign sb_seq = utf8_encode(sb_cp);

   always_comb begin
      pos_in = pos_ff;
      held_in = held_ff;
      phase_in = phase_ff;
      be_in = be_ff;
      stop_in = stop_ff;
      seq = '0;
      do_pair = 1'b0;
      if (accept) begin
         if (!pos_ff[1]) begin
            pos_in = pos_ff + 2'd1;
         end
         if (!stop_ff) begin
            case (enc_ff)
               ENC_SINGLE: begin
                  seq = sb_seq;
               end
               ENC_BOM: begin
                  if (pos_ff == 2'd0) begin
                     be_in = (req_in_byte == BOM_BIG_FIRST);
                  end else if (pos_ff[1]) begin
                     do_pair = 1'b1;
                  end
               end
               ENC_BE: begin
                  do_pair = 1'b1;
               end
               default: begin
                  seq.bytes[0] = req_in_byte;
                  seq.cnt = 2'd1;
               end
            endcase
         end
         if (do_pair) begin
            if (!phase_ff) begin
               held_in = req_in_byte;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               // a zero unit silences the rest of the string
               if (unit == 16'h0000) begin
                  stop_in = 1'b1;
               end else begin
                  seq = unit_seq;
               end
            end
         end
         if (req_last_in_string) begin
            pos_in = 2'd0;
            held_in = 8'h00;
            phase_in = 1'b0;
            be_in = 1'b0;
            stop_in = 1'b0;
         end
      end
   end

   // a string end with no data still leaves a bare marker word
   assign push = accept && ((seq.cnt != 2'd0) || req_last_in_string);
   assign job.bytes = seq.bytes;
   assign job.cnt = (seq.cnt != 2'd0) ? seq.cnt : 2'd1;
   assign job.data = (seq.cnt != 2'd0);
   assign job.last = req_last_in_string;

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff <= ENC_SINGLE;
         cyr_ff <= 1'b0;
         pos_ff <= 2'd0;
         held_ff <= 8'h00;
         phase_ff <= 1'b0;
         be_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TEXT_ENCODING) begin
               enc_ff <= csr_data;
            end else if (csr_index == CSR_CYRILLIC_MODE) begin
               cyr_ff <= csr_data[0];
            end
         end
         pos_ff <= pos_in;
         held_ff <= held_in;
         phase_ff <= phase_in;
         be_ff <= be_in;
         stop_ff <= stop_in;
      end
   end

endmodule

// ===== hw/rtl/tt8_queue.sv =====
module tt8_queue #(
   parameter int DEPTH = tt8_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tt8_pkg::tt8_job_type      push_job,
   input  logic                      pop,
   output tt8_pkg::tt8_job_type      head,
   output tt8_pkg::tt8_q_status_type status
);
   import tt8_pkg::*;

   localparam int AW = $clog2(DEPTH);

   tt8_job_type   mem_ff [DEPTH];
   logic [AW:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW:0]   rd_ptr_ff, rd_ptr_in;

   assign status.empty = (wr_ptr_ff == rd_ptr_ff);
   assign status.full = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                        (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign head = mem_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = push ? wr_ptr_ff + (AW+1)'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + (AW+1)'(1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= push_job;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue read while empty");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !status.empty)
      else $error("queue empty after a push");
`endif

endmodule

// ===== hw/rtl/tt8_back.sv =====
module tt8_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tt8_pkg::tt8_job_type      head,
   input  tt8_pkg::tt8_q_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_run_last,
   output logic                      rsp_string_end
);
   import tt8_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       data_ff, data_in;
   logic       run_last_ff, run_last_in;
   logic       end_ff, end_in;
   logic       load;
   logic       at_last;
   logic [7:0] cur_byte;

   assign load = !q_status.empty && (!valid_ff || rsp_ready);
   assign at_last = ((idx_ff + 2'd1) == head.cnt);
   assign pop = load && at_last;

   always_comb begin
      case (idx_ff)
         2'd0: cur_byte = head.bytes[0];
         2'd1: cur_byte = head.bytes[1];
         default: cur_byte = head.bytes[2];
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in = byte_ff;
      data_in = data_ff;
      run_last_in = run_last_ff;
      end_in = end_ff;
      if (load) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         byte_in = cur_byte;
         data_in = head.data;
         run_last_in = at_last;
         end_in = at_last && head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      data_ff <= data_in;
      run_last_ff <= run_last_in;
      end_ff <= end_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_byte_valid = data_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_string_end = end_ff;

`ifndef SYNTH
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> (idx_ff < head.cnt))
      else $error("byte index beyond queued job");
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && end_ff |-> run_last_ff)
      else $error("string end on a word that does not close its run");
   a_marker_closes: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff |-> run_last_ff && end_ff)
      else $error("bare marker that does not end the string");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import tt8_pkg::*;

   localparam logic [7:0] ENC_PASS     = 8'h03;
   localparam logic [7:0] ENC_PASS_TOP = 8'hFF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;

   // windows-1251 code points for bytes 0x80-0xFF
   localparam logic [15:0] CP1251_UPPER [128] = '{
      16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
      16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
      16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
      16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
      16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
      16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
      16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
      16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
      16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
      16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
      16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
      16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
      16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
      16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       string_end;
   } utf8_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_in_byte = '0;
   logic                 req_last_in_string = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_run_last;
   logic                 rsp_string_end;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_data = '0;

   // transcoder model: configuration and per-string state
   logic [7:0] cfg_encoding = ENC_SINGLE;
   logic       cfg_cyrillic = 1'b0;
   logic [1:0] str_pos = '0;
   logic [7:0] pend_byte = '0;
   logic       pend_valid = 1'b0;
   logic       bom_big = 1'b0;
   logic       text_halted = 1'b0;

   utf8_word_type expected_utf8[$];
   utf8_word_type got_word;
   utf8_word_type want_word;
   int            mismatches = 0;
   int            stall_cycles = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;

   tag_text_to_utf8_transcoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .req_last_in_string (req_last_in_string),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_end     (rsp_string_end),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // works out the utf-8 words that one raw byte causes
   task automatic predict_utf8(input logic [7:0] b, input logic last);
      logic [7:0]    seq [3];
      logic [1:0]    pos;
      logic [15:0]   cp;
      logic [15:0]   unit;
      logic          have_cp;
      logic          pairing;
      logic          order;
      int            n;
      utf8_word_type w;
      seq[0] = '0;
      seq[1] = '0;
      seq[2] = '0;
      cp = '0;
      have_cp = 1'b0;
      pairing = 1'b0;
      order = 1'b1;
      n = 0;
      pos = str_pos;
      if (str_pos < 2) str_pos = str_pos + 2'd1;
      if (!text_halted) begin
         if (cfg_encoding == ENC_SINGLE) begin
            have_cp = 1'b1;
            cp = (cfg_cyrillic && b[7]) ? CP1251_UPPER[b[6:0]] : {8'h00, b};
         end else if (cfg_encoding == ENC_BOM) begin
            if (pos == 0) begin
               bom_big = (b == BOM_BIG_FIRST);
            end else if (pos >= 2) begin
               pairing = 1'b1;
               order = bom_big;
            end
         end else if (cfg_encoding == ENC_BE) begin
            pairing = 1'b1;
         end else begin
            seq[0] = b;
            n = 1;
         end
      end
      if (pairing) begin
         if (!pend_valid) begin
            pend_byte = b;
            pend_valid = 1'b1;
         end else begin
            pend_valid = 1'b0;
            unit = order ? {pend_byte, b} : {b, pend_byte};
            if (unit == 16'h0000) begin
               text_halted = 1'b1;
            end else begin
               have_cp = 1'b1;
               cp = unit;
            end
         end
      end
      if (have_cp) begin
         if (cp <= 16'h007F) begin
            seq[0] = cp[7:0];
            n = 1;
         end else if (cp <= 16'h07FF) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            n = 2;
         end else begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            n = 3;
         end
      end
      for (int k = 0; k < n; k++) begin
         w.out_byte = seq[k];
         w.byte_valid = 1'b1;
         w.run_last = (k == n - 1);
         w.string_end = last && (k == n - 1);
         expected_utf8 = {expected_utf8, w};
      end
      if (last) begin
         if (n == 0) begin
            w = '{8'h00, 1'b0, 1'b1, 1'b1};
            expected_utf8 = {expected_utf8, w};
         end
         str_pos = '0;
         pend_byte = '0;
         pend_valid = 1'b0;
         bom_big = 1'b0;
         text_halted = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = '{rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_string_end};
         if (expected_utf8.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected word: byte %02h valid %0b run_last %0b end %0b",
                        got_word.out_byte, got_word.byte_valid, got_word.run_last,
                        got_word.string_end);
            mismatches++;
         end else begin
            want_word = expected_utf8.pop_front();
            if (got_word !== want_word) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("mismatch: expected byte %02h valid %0b run_last %0b end %0b",
                           want_word.out_byte, want_word.byte_valid, want_word.run_last,
                           want_word.string_end);
                  $display("          actual   byte %02h valid %0b run_last %0b end %0b",
                           got_word.out_byte, got_word.byte_valid, got_word.run_last,
                           got_word.string_end);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tag_text_to_utf8_transcoder verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_last_in_string <= last;
      predict_utf8(b, last);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_string(input logic [7:0] text[$]);
      foreach (text[i]) send_word(text[i], i == text.size() - 1);
   endtask

   // pause covers words that give no output but may still be in flight
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_utf8.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TEXT_ENCODING) cfg_encoding = value;
      else if (idx == CSR_CYRILLIC_MODE) cfg_cyrillic = value[0];
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [7:0] enc, input logic cyr);
      wait_drained();
      write_reg(CSR_TEXT_ENCODING, enc);
      write_reg(CSR_CYRILLIC_MODE, {7'd0, cyr});
   endtask

   task automatic test_latin1();
      logic [7:0] text[$];
      set_mode(ENC_SINGLE, 1'b0);
      text = '{8'h7F, 8'h80, 8'hFF};
      send_string(text);
   endtask

   task automatic test_cyrillic();
      logic [7:0] text[$];
      set_mode(ENC_SINGLE, 1'b1);
      text = '{8'h80, 8'h88, 8'hFF};
      send_string(text);
   endtask

   task automatic test_utf16_bom();
      logic [7:0] text[$];
      set_mode(ENC_BOM, 1'b0);
      // big endian, odd byte at the end is dropped
      text = '{BOM_BIG_FIRST, 8'hFF, 8'h20, 8'hAC, 8'h00};
      send_string(text);
      // little endian, zero unit halts the string
      text = '{8'hFF, 8'hFE, 8'h41, 8'h00, 8'h00, 8'h00};
      send_string(text);
      // too short for a bom, only the end marker
      text = '{BOM_BIG_FIRST};
      send_string(text);
   endtask

   task automatic test_utf16_be();
      logic [7:0] text[$];
      set_mode(ENC_BE, 1'b0);
      text = '{8'hFF, 8'hFF, 8'h07, 8'hFF};
      send_string(text);
   endtask

   task automatic test_passthrough();
      set_mode(ENC_PASS_TOP, 1'b1);
      send_word(8'h80, 1'b1);
   endtask

   task automatic test_mode_change_mid_string();
      set_mode(ENC_SINGLE, 1'b0);
      send_word(8'h41, 1'b0);
      // second byte of the string lands on the bom slot, third starts a unit
      set_mode(ENC_BOM, 1'b0);
      send_word(8'h42, 1'b0);
      send_word(8'h43, 1'b1);
   endtask

   task automatic test_random_strings(input int target);
      logic [7:0]  text[$];
      logic [15:0] unit;
      logic        big;
      int          sent;
      int          len;
      sent = 0;
      while (sent < target) begin
         if (sent == 0 || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2: set_mode(ENC_SINGLE, 1'($urandom_range(0, 1)));
               3, 4:    set_mode(ENC_BOM, 1'($urandom_range(0, 1)));
               5, 6:    set_mode(ENC_BE, 1'($urandom_range(0, 1)));
               7:       set_mode(ENC_PASS, 1'($urandom_range(0, 1)));
               8:       set_mode(ENC_PASS_TOP, 1'($urandom_range(0, 1)));
               default: set_mode(8'($urandom_range(4, 254)), 1'($urandom_range(0, 1)));
            endcase
         end
         text = {};
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         if ((cfg_encoding == ENC_BOM || cfg_encoding == ENC_BE) &&
             $urandom_range(0, 4) != 0) begin
            // well-formed utf-16, now and then an odd tail
            big = 1'b1;
            if (cfg_encoding == ENC_BOM) begin
               if ($urandom_range(0, 1) == 1) text = '{BOM_BIG_FIRST, 8'hFF};
               else text = '{8'hFF, 8'hFE};
               big = (text[0] == BOM_BIG_FIRST);
            end
            repeat ((len + 1) / 2) begin
               case ($urandom_range(0, 15))
                  0:             unit = 16'h0000;
                  1, 2, 3, 4, 5: unit = 16'($urandom_range(16'h0001, 16'h007F));
                  6, 7, 8, 9:    unit = 16'($urandom_range(16'h0080, 16'h07FF));
                  default:       unit = 16'($urandom_range(16'h0800, 16'hFFFF));
               endcase
               if (big) begin
                  text = {text, unit[15:8], unit[7:0]};
               end else begin
                  text = {text, unit[7:0], unit[15:8]};
               end
            end
            if ($urandom_range(0, 4) == 0) text = {text, 8'($urandom)};
         end else begin
            repeat (len) text = {text, 8'($urandom)};
         end
         sent += text.size();
         send_string(text);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 74;
      test_latin1();
      test_cyrillic();
      test_utf16_bom();
      test_utf16_be();
      test_passthrough();
      test_mode_change_mid_string();
      test_random_strings(100);

      send_idle_pct = 74;
      recv_idle_pct = 34;
      test_random_strings(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(100);

      req_valid <= 1'b0;
      while (expected_utf8.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_utf8.size() == 0) begin
         $display("tag_text_to_utf8_transcoder verification clean");
      end else begin
         $display("tag_text_to_utf8_transcoder verification failed");
      end
      $finish;
   end

endmodule
